>>> src/dmacb_pkg.sv
// Package for the DMA descriptor chain builder.
// Holds the command types, field widths and fixed constants shared by all modules.
// No dependencies.
package dmacb_pkg;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 128;
   localparam int CSR_WDATA_W = 20;

   localparam int PAGE_W   = 12;
   localparam int FRAME_W  = 20;
   localparam int LEN_W    = 17;
   localparam int OFFS_W   = 17;
   localparam int COUNT_W  = 13;
   localparam int PIDX_W   = 5;
   localparam int BURST_W  = 4;
   localparam int PIECE_W  = 6;
   localparam int DESC_SHIFT = 5;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [LEN_W-1:0]   MAX_LEN     = 17'd65536;
   localparam logic [COUNT_W-1:0] PAGE_BYTES  = 13'd4096;
   localparam logic [11:0]        XFER_FLAGS  = 12'h330;
   localparam logic [BURST_W-1:0] BURST_RESET = 4'd4;
   localparam logic [FRAME_W-1:0] DFRAME_RESET = 20'd0;

   localparam logic CSR_BURST_LENGTH     = 1'b0;
   localparam logic CSR_DESCRIPTOR_FRAME = 1'b1;

   typedef enum logic [1:0] {
      MODE_LOAD_SRC = 2'd0,
      MODE_LOAD_DST = 2'd1,
      MODE_BUILD    = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type              kind;
      logic [PIDX_W-1:0]     page_index;
      logic [FRAME_W-1:0]    frame_number;
      logic [PAGE_W-1:0]     src_page_offset;
      logic [PAGE_W-1:0]     dst_page_offset;
      logic [LEN_W-1:0]      length;
   } cmd_type;

endpackage

>>> src/dmacb_front.sv
// Front end of the DMA descriptor chain builder: accepts request transactions,
// classifies them, drops those without effect and queues the rest for the back end.
// Depends on dmacb_pkg.
module dmacb_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata from bit 0: page_index, frame_number, src_page_offset,
   // dst_page_offset, length, zero fill
   input  logic [dmacb_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: mode
   input  logic [1:0]                        req_tuser,
   output logic                              cmd_valid,
   output dmacb_pkg::cmd_type                cmd,
   input  logic                              cmd_pop
);

   dmacb_pkg::cmd_type                     queue_ff [dmacb_pkg::QUEUE_DEPTH];
   logic                                   wr_ptr_ff, wr_ptr_in;
   logic                                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]                             count_ff, count_in;
   dmacb_pkg::cmd_type                     cls;
   logic                                   keep;
   logic                                   push;
   logic [dmacb_pkg::LEN_W-1:0]            raw_len;

   assign raw_len = req_tdata[65:49];

   always_comb begin
      cls.kind            = dmacb_pkg::MODE_BUILD;
      cls.page_index      = req_tdata[4:0];
      cls.frame_number    = req_tdata[24:5];
      cls.src_page_offset = req_tdata[36:25];
      cls.dst_page_offset = req_tdata[48:37];
      cls.length          = (raw_len > dmacb_pkg::MAX_LEN) ? dmacb_pkg::MAX_LEN : raw_len;
      keep                = 1'b0;
      unique case (req_tuser)
         2'(dmacb_pkg::MODE_LOAD_SRC): begin
            cls.kind = dmacb_pkg::MODE_LOAD_SRC;
            keep     = 1'b1;
         end
         2'(dmacb_pkg::MODE_LOAD_DST): begin
            cls.kind = dmacb_pkg::MODE_LOAD_DST;
            keep     = 1'b1;
         end
         2'(dmacb_pkg::MODE_BUILD): begin
            cls.kind = dmacb_pkg::MODE_BUILD;
            keep     = (raw_len != '0);
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_tready = (count_ff != 2'(dmacb_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && keep;
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> src/dmacb_back.sv
// Back end of the DMA descriptor chain builder: holds the page-frame tables,
// walks a copy page by page and drives the descriptor output register.
// Depends on dmacb_pkg.
module dmacb_back #(
   parameter int PAGE_ENTRIES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   input  dmacb_pkg::cmd_type                  cmd,
   output logic                                cmd_pop,
   input  logic [dmacb_pkg::BURST_W-1:0]       burst_length,
   input  logic [dmacb_pkg::FRAME_W-1:0]       descriptor_frame,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dmacb_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int AW = $clog2(PAGE_ENTRIES);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   logic [dmacb_pkg::FRAME_W-1:0] src_mem [PAGE_ENTRIES];
   logic [dmacb_pkg::FRAME_W-1:0] dst_mem [PAGE_ENTRIES];
   logic [dmacb_pkg::FRAME_W-1:0] src_rd_ff;
   logic [dmacb_pkg::FRAME_W-1:0] dst_rd_ff;

   state_type                     state_ff, state_in;
   logic [dmacb_pkg::OFFS_W-1:0]  so_ff, so_in;
   logic [dmacb_pkg::OFFS_W-1:0]  do_ff, do_in;
   logic [dmacb_pkg::LEN_W-1:0]   rem_ff, rem_in;
   logic [dmacb_pkg::PIECE_W-1:0] n_ff, n_in;
   logic                          out_valid_ff, out_valid_in;
   logic [dmacb_pkg::RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   logic                          out_last_ff, out_last_in;

   logic                          adv;
   logic                          start;
   logic                          wr_src, wr_dst;
   logic                          rd_en;
   logic [AW-1:0]                 wr_addr;
   logic [AW-1:0]                 src_raddr, dst_raddr;
   logic [dmacb_pkg::COUNT_W-1:0] s_room, d_room, room, piece;
   logic                          fin;
   logic [31:0]                   next_addr;
   logic [11:0]                   next_off;
   logic [15:0]                   info;

   always_comb begin
      s_room  = dmacb_pkg::PAGE_BYTES - {1'b0, so_ff[11:0]};
      d_room  = dmacb_pkg::PAGE_BYTES - {1'b0, do_ff[11:0]};
      room    = (d_room < s_room) ? d_room : s_room;
      fin     = (rem_ff <= {4'b0, room});
      piece   = fin ? rem_ff[dmacb_pkg::COUNT_W-1:0] : room;
      next_off = {(7'(n_ff) + 7'd1), dmacb_pkg::DESC_SHIFT'(0)};
      next_addr = fin ? 32'd0 : {descriptor_frame, next_off};
      info    = {burst_length, dmacb_pkg::XFER_FLAGS};
   end

   assign adv     = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_tready);
   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;
   assign start   = cmd_pop && (cmd.kind == dmacb_pkg::MODE_BUILD);
   assign wr_addr = AW'(cmd.page_index);
   assign wr_src  = cmd_pop && (cmd.kind == dmacb_pkg::MODE_LOAD_SRC)
                    && (32'(cmd.page_index) < PAGE_ENTRIES);
   assign wr_dst  = cmd_pop && (cmd.kind == dmacb_pkg::MODE_LOAD_DST)
                    && (32'(cmd.page_index) < PAGE_ENTRIES);
   assign rd_en   = start || adv;

   always_comb begin
      state_in     = state_ff;
      so_in        = so_ff;
      do_in        = do_ff;
      rem_in       = rem_ff;
      n_in         = n_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               so_in    = {5'b0, cmd.src_page_offset};
               do_in    = {5'b0, cmd.dst_page_offset};
               rem_in   = cmd.length;
               n_in     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (adv) begin
               out_valid_in = 1'b1;
               out_data_in  = {3'b0, next_addr, piece,
                               {dst_rd_ff, do_ff[11:0]},
                               {src_rd_ff, so_ff[11:0]}, info};
               out_last_in  = fin;
               so_in        = so_ff + dmacb_pkg::OFFS_W'(piece);
               do_in        = do_ff + dmacb_pkg::OFFS_W'(piece);
               rem_in       = rem_ff - dmacb_pkg::LEN_W'(piece);
               n_in         = n_ff + dmacb_pkg::PIECE_W'(1);
               if (fin) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign src_raddr = start ? '0 : AW'(so_in[16:12]);
   assign dst_raddr = start ? '0 : AW'(do_in[16:12]);

   always_ff @(posedge clock) begin
      if (wr_src) begin
         src_mem[wr_addr] <= cmd.frame_number;
      end
      if (rd_en) begin
         src_rd_ff <= src_mem[src_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_dst) begin
         dst_mem[wr_addr] <= cmd.frame_number;
      end
      if (rd_en) begin
         dst_rd_ff <= dst_mem[dst_raddr];
      end
   end

   always_ff @(posedge clock) begin
      so_ff       <= so_in;
      do_ff       <= do_in;
      rem_ff      <= rem_in;
      n_ff        <= n_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE) && cmd_valid)
      else $error("command popped while the engine was busy");

   a_emit_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rem_ff != '0) && (n_ff < 6'd33))
      else $error("engine emitting with no bytes left or too many pieces");

   a_adv_loads_output: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_tvalid)
      else $error("descriptor lost after advance");

   a_last_ends_chain: assert property (@(posedge clock) disable iff (reset)
      adv && fin |=> (state_ff == ST_IDLE) && rsp_tlast)
      else $error("final piece did not end the chain");
`endif

endmodule

>>> src/dma_descriptor_chain_builder.sv
// Top level of the DMA descriptor chain builder: configuration registers and
// the connection of the front end, with its command queue, and the back end.
// Depends on dmacb_pkg, dmacb_front and dmacb_back.
//
//   Channel  Direction  Handshake              Content
//   req_     in         req_tvalid/req_tready  load source, load destination or start
//   rsp_     out        rsp_tvalid/rsp_tready  one descriptor per page piece
//   csr_     in         csr_we                 burst_length, descriptor_frame
//
// A load transaction is written to its table as it is popped; a start reads the first
// frames, then emits one descriptor per page piece, up to 33 descriptors, at one
// descriptor per cycle from the back end's piece loop while the output is not stalled.
// A two-entry command queue lets the front end accept while the back end works.
// Reset sets control state and the registers to defaults; page-frame tables are kept.
// A stalled output holds the back end in place until the descriptor is taken.
module dma_descriptor_chain_builder #(
   parameter int PAGE_ENTRIES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_tdata from bit 0: page_index, frame_number, src_page_offset,
   // dst_page_offset, length, zero fill
   input  logic [dmacb_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_tuser: mode
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata from bit 0: transfer_info, source_address, dest_address,
   // byte_count, next_address, zero fill
   output logic [dmacb_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [dmacb_pkg::CSR_WDATA_W-1:0]   csr_wdata
);

   logic [dmacb_pkg::BURST_W-1:0] burst_ff, burst_in;
   logic [dmacb_pkg::FRAME_W-1:0] dframe_ff, dframe_in;
   logic                          cmd_valid;
   logic                          cmd_pop;
   dmacb_pkg::cmd_type            cmd;

   always_comb begin
      burst_in  = burst_ff;
      dframe_in = dframe_ff;
      if (csr_we) begin
         unique case (csr_index)
            dmacb_pkg::CSR_BURST_LENGTH:     burst_in  = csr_wdata[3:0];
            dmacb_pkg::CSR_DESCRIPTOR_FRAME: dframe_in = csr_wdata;
            default:                         burst_in  = burst_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff  <= dmacb_pkg::BURST_RESET;
         dframe_ff <= dmacb_pkg::DFRAME_RESET;
      end else begin
         burst_ff  <= burst_in;
         dframe_ff <= dframe_in;
      end
   end

   dmacb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   dmacb_back #(
      .PAGE_ENTRIES (PAGE_ENTRIES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .burst_length     (burst_ff),
      .descriptor_frame (dframe_ff),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast)
   );

endmodule
